>>> rtl/prefix_code_bit_packer_top_macros.svh
// ----------------------------------------------------------------------------
// prefix code bit packer assertion macros
// concurrent assertion helpers used by the top level rtl file
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_PACKER_TOP_MACROS_SVH
`define PREFIX_CODE_BIT_PACKER_TOP_MACROS_SVH

// clocked check, disabled while reset is held
`define PCBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define PCBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg
// shared types and constants of the prefix code bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcbp_pkg;

  localparam int WORD_BITS = 16;
  localparam int CODE_W    = 32;
  localparam int LEN_IN_W  = 6;
  localparam int SYM_W     = 8;

  // request op codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t word;
    logic  kind;
    logic  last;
  } res_t;

  // up to two results produced by one request
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  // control of the request in the lookup stage
  typedef struct packed {
    logic [1:0] op;
    logic       hit;
  } item_ctl_t;

endpackage

>>> rtl/pcbp_if.sv
// ----------------------------------------------------------------------------
// pcbp channel interfaces
// valid/ready request and result channels of the prefix code bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcbp_in_if;
  import pcbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [SYM_W-1:0]    symbol;
  logic [CODE_W-1:0]   code_bits;
  logic [LEN_IN_W-1:0] code_len;

  modport source (output valid, op, symbol, code_bits, code_len, input ready);
  modport sink   (input valid, op, symbol, code_bits, code_len, output ready);
endinterface

interface pcbp_out_if;
  import pcbp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] out_word;
  logic                 kind;
  logic                 last;

  modport source (output valid, out_word, kind, last, input ready);
  modport sink   (input valid, out_word, kind, last, output ready);
endinterface

>>> rtl/pcbp_ram.sv
// ----------------------------------------------------------------------------
// pcbp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcbp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/pcbp_core.sv
// ----------------------------------------------------------------------------
// pcbp_core
// bit accumulator, fill count and halt state with the word packing logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcbp_core #(
  parameter int LEN_W = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  pcbp_pkg::item_ctl_t          ctl,
  input  logic [pcbp_pkg::CODE_W-1:0]  code,
  input  logic [LEN_W-1:0]             len,
  output pcbp_pkg::res_pair_t          pair
);
  import pcbp_pkg::*;

  word_t      acc_r,  acc_nxt;
  logic [3:0] fill_r, fill_nxt;
  logic       halted_r, halted_nxt;

  logic [5:0]        n6;
  logic [5:0]        total;
  logic [CODE_W-1:0] code_al;
  word_t             acc_al;
  logic [47:0]       stream;
  logic [1:0]        nwords;
  logic [3:0]        new_fill;
  word_t             rem;
  word_t             new_acc;

  // pending bits followed by the new code, left aligned
  assign n6      = 6'(len);
  assign code_al = code << (6'd32 - n6);
  assign acc_al  = acc_r << (5'd16 - {1'b0, fill_r});
  assign stream  = {acc_al, 32'h0} | ({code_al, 16'h0} >> fill_r);
  assign total   = {2'b00, fill_r} + n6;
  assign nwords  = total[5] ? 2'd2 : (total[4] ? 2'd1 : 2'd0);
  assign new_fill = total[3:0];

  always_comb begin
    case (nwords)
      2'd0:    rem = stream[47:32];
      2'd1:    rem = stream[31:16];
      default: rem = stream[15:0];
    endcase
  end

  assign new_acc = rem >> (5'd16 - {1'b0, new_fill});

  always_comb begin
    pair       = '0;
    acc_nxt    = acc_r;
    fill_nxt   = fill_r;
    halted_nxt = halted_r;
    case (ctl.op)
      OP_ENCODE: begin
        if (halted_r || !ctl.hit) begin
          pair.cnt     = 2'd1;
          pair.r0.kind = KIND_ERROR;
          pair.r0.last = 1'b1;
          halted_nxt   = 1'b1;
        end else begin
          pair.cnt     = nwords;
          pair.r0.word = stream[47:32];
          pair.r0.kind = KIND_DATA;
          pair.r0.last = (nwords == 2'd1);
          pair.r1.word = stream[31:16];
          pair.r1.kind = KIND_DATA;
          pair.r1.last = 1'b1;
          acc_nxt      = new_acc;
          fill_nxt     = new_fill;
        end
      end
      OP_FLUSH: begin
        if (halted_r) begin
          pair.cnt     = 2'd1;
          pair.r0.kind = KIND_ERROR;
          pair.r0.last = 1'b1;
        end else if (fill_r != 4'd0) begin
          pair.cnt     = 2'd1;
          pair.r0.word = acc_al;
          pair.r0.kind = KIND_DATA;
          pair.r0.last = 1'b1;
          acc_nxt      = '0;
          fill_nxt     = 4'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      fill_r   <= 4'd0;
      halted_r <= 1'b0;
    end else if (adv) begin
      acc_r    <= acc_nxt;
      fill_r   <= fill_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> rtl/pcbp_out_buf.sv
// ----------------------------------------------------------------------------
// pcbp_out_buf
// two entry buffer driving the result channel one word a cycle while ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcbp_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcbp_pkg::res_pair_t pair,
  output logic                buf_free,
  pcbp_out_if.source          out_if
);
  import pcbp_pkg::*;

  res_t       e0_r, e0_nxt;
  res_t       e1_r, e1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop      = out_if.valid && out_if.ready;
  assign buf_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    if (push) begin
      e0_nxt  = pair.r0;
      e1_nxt  = pair.r1;
      cnt_nxt = pair.cnt;
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign out_if.valid    = (cnt_r != 2'd0);
  assign out_if.out_word = e0_r.word;
  assign out_if.kind     = e0_r.kind;
  assign out_if.last     = e0_r.last;

endmodule

>>> rtl/prefix_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_top
// packs variable length prefix codes into 16-bit words, msb first
// ----------------------------------------------------------------------------
// pipeline: lookup stage register, then result buffer register
// throughput: one request a cycle while results fit; a two-word encode holds
//   the lookup stage, as the result buffer drains one word a cycle on ready
// reset: synchronous, clears entry valid bits, accumulator, fill count,
//   halt flag and pipeline; code table ram is undefined until loaded
`timescale 1ns / 1ps

`include "prefix_code_bit_packer_top_macros.svh"

module prefix_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  pcbp_in_if.sink    in_if,
  pcbp_out_if.source out_if
);
  import pcbp_pkg::*;

  // saturation cap of a loaded length and derived widths
  localparam int CAP    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int LEN_W  = $clog2(CAP + 1);
  localparam int AW     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int RAM_W  = CODE_W + LEN_W;

  logic              in_acc;
  logic              sym_ok;
  logic [AW-1:0]     sym_idx;
  logic [LEN_W-1:0]  len_sat;
  logic              tbl_wr;

  logic [NUM_SYMBOLS-1:0] valid_r, valid_nxt;

  // lookup stage, holds the request while the ram read data is in flight
  logic       s1_v_r, s1_v_nxt;
  item_ctl_t  s1_ctl_r, s1_ctl_nxt;
  logic       s1_adv;

  logic [RAM_W-1:0] rd_data;
  res_pair_t        pair;
  logic             buf_free;
  logic             push;

  assign in_acc  = in_if.valid && in_if.ready;
  assign sym_idx = in_if.symbol[AW-1:0];
  // symbols beyond the table are unknown on encode and ignored on load
  assign sym_ok  = ({1'b0, in_if.symbol} < 9'(NUM_SYMBOLS));
  assign len_sat = (in_if.code_len > LEN_IN_W'(CAP)) ? LEN_W'(CAP)
                                                     : in_if.code_len[LEN_W-1:0];
  assign tbl_wr  = in_acc && (in_if.op == OP_LOAD) && sym_ok;

  // code table: code bits and saturated length, written on load request
  pcbp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_SYMBOLS),
    .ADDR_W(AW)
  ) u_table (
    .clk    (clk),
    .wr_en  (tbl_wr),
    .wr_addr(sym_idx),
    .wr_data({in_if.code_bits, len_sat}),
    .rd_en  (in_acc),
    .rd_addr(sym_idx),
    .rd_data(rd_data)
  );

  // entry valid flags, one flop per symbol
  always_comb begin
    valid_nxt = valid_r;
    if (tbl_wr) begin
      valid_nxt[sym_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // lookup stage moves on when its results fit in the result buffer
  assign s1_adv     = s1_v_r && ((pair.cnt == 2'd0) || buf_free);
  assign push       = s1_adv && (pair.cnt != 2'd0);
  assign in_if.ready = !s1_v_r || s1_adv;

  always_comb begin
    s1_v_nxt   = s1_v_r;
    s1_ctl_nxt = s1_ctl_r;
    if (in_acc) begin
      s1_v_nxt       = 1'b1;
      s1_ctl_nxt.op  = in_if.op;
      s1_ctl_nxt.hit = sym_ok && valid_r[sym_idx];
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r <= s1_ctl_nxt;
  end

  // packing logic and accumulator state
  pcbp_core #(
    .LEN_W(LEN_W)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (s1_adv),
    .ctl  (s1_ctl_r),
    .code (rd_data[RAM_W-1:LEN_W]),
    .len  (rd_data[LEN_W-1:0]),
    .pair (pair)
  );

  // result buffer on the output channel
  pcbp_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pair    (pair),
    .buf_free(buf_free),
    .out_if  (out_if)
  );

  // a stalled lookup stage keeps its request
  `PCBP_ASSERT(a_s1_hold, clk, rst_n, s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_ctl_r), "lookup stage lost a stalled request")
  // only data words of a two-word encode come without last
  `PCBP_ASSERT(a_mid_is_data, clk, rst_n, out_if.valid && !out_if.last |-> out_if.kind == KIND_DATA, "non-final result is not a data word")
  // error results are single, final and carry a zero word
  `PCBP_ASSERT(a_err_form, clk, rst_n, out_if.valid && (out_if.kind == KIND_ERROR) |-> out_if.last && (out_if.out_word == '0), "malformed error result")

endmodule

>>> tb/tb_prefix_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// tb_prefix_code_bit_packer_top
// self-checking bench for the prefix code bit packer: a table of directed
// requests, then random load / encode / flush traffic, every result compared
// against a cycle-free packing predictor or a typed-in expectation; ends with
// the halt-on-unknown-symbol sequence, since only reset clears the halt
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_prefix_code_bit_packer_top;
  import pcbp_pkg::*;

  localparam int P_MAX_CODE_LEN = 32;
  localparam int P_NUM_SYMBOLS  = 256;
  localparam int LEN_CAP        = (P_MAX_CODE_LEN < 32) ? P_MAX_CODE_LEN : 32;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // never loaded before the closing rows, so encoding it trips the halt
  localparam logic [7:0] UNKNOWN_SYM = 8'hC3;

  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTED  = 200;

  typedef struct packed {
    logic [15:0] word;
    logic        kind;
    logic        last;
  } word_res_t;

  // where the expected results of a table row come from
  typedef enum logic {CHECK_PREDICTED, CHECK_FIXED} exp_src_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] bits;
    logic [5:0]  len;
    exp_src_t    src;
    logic [1:0]  n;
    logic        kind;
    logic [15:0] w0;
    logic [15:0] w1;
  } stim_row_t;

  localparam int NUM_ROWS = 30;
  localparam int HALT_ROW = 22;

  // rows before HALT_ROW run first; the rest close the run after the random part
  stim_row_t plan [NUM_ROWS] = '{
    // empty flush and unused op right after reset
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    // exactly one word of ones
    '{OP_LOAD,   8'h00, 32'h0000_FFFF, 6'd16, CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd1, KIND_DATA, 16'hFFFF, 16'h0},
    // longest code fills two words at once
    '{OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd2, KIND_DATA, 16'hFFFF, 16'hFFFF},
    // empty code appends nothing
    '{OP_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd0,  CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'd63, CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    // three bits then a padded flush
    '{OP_LOAD,   8'h02, 32'h0000_0005, 6'd3,  CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd1, KIND_DATA, 16'hA000, 16'h0},
    '{OP_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63, CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    // overlong lengths saturate
    '{OP_LOAD,   8'h80, 32'hAAAA_AAAA, 6'd63, CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  CHECK_PREDICTED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  CHECK_PREDICTED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_LOAD,   8'h7F, 32'h1234_5678, 6'd33, CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  CHECK_PREDICTED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    // single zero bit, upper code bits ignored
    '{OP_LOAD,   8'h55, 32'hFFFF_FFFE, 6'd1,  CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'h55, 32'h0000_0000, 6'd0,  CHECK_PREDICTED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    // table entry overwritten with a new length
    '{OP_LOAD,   8'h00, 32'hFFFF_CAD3, 6'd15, CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  CHECK_PREDICTED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  CHECK_PREDICTED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    // closing rows: leave bits pending, then the unknown symbol halts the packer
    '{OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  CHECK_PREDICTED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, UNKNOWN_SYM, 32'h0,   6'd0,  CHECK_FIXED, 2'd1, KIND_ERROR, 16'h0, 16'h0},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd1, KIND_ERROR, 16'h0, 16'h0},
    '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd1, KIND_ERROR, 16'h0, 16'h0},
    // loads still go in while halted, encodes still fail
    '{OP_LOAD,   UNKNOWN_SYM, 32'h1,   6'd1,  CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_ENCODE, UNKNOWN_SYM, 32'h0,   6'd0,  CHECK_FIXED, 2'd1, KIND_ERROR, 16'h0, 16'h0},
    '{OP_UNUSED, 8'h00, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd0, KIND_DATA, 16'h0, 16'h0},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  CHECK_FIXED, 2'd1, KIND_ERROR, 16'h0, 16'h0}
  };

  logic clk;
  logic rst_n;

  pcbp_in_if  in_ch ();
  pcbp_out_if out_ch ();

  prefix_code_bit_packer_top #(
    .MAX_CODE_LEN (P_MAX_CODE_LEN),
    .NUM_SYMBOLS  (P_NUM_SYMBOLS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // 10 ns clock, first rising edge at 5 ns
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state: code table, packing accumulator, halt flag
  logic [31:0] code_mem    [P_NUM_SYMBOLS];
  logic [5:0]  len_mem     [P_NUM_SYMBOLS];
  bit          code_loaded [P_NUM_SYMBOLS];
  logic [15:0] acc_bits;
  int          acc_fill;
  bit          packer_halted;

  word_res_t   pending_words [$];
  logic [7:0]  loaded_syms   [$];

  int  mismatches;
  int  cycles;
  int  n_loads, n_encodes, n_flushes, n_unused;
  int  n_words, n_errors, n_pairs;
  bit  calm;       // no idling on either side while set
  bit  hold_req;   // asks the receiver for a long hold-off

  // applies one request to the predictor, returns the words it produces
  function automatic int pack_request(input logic [1:0] op, input logic [7:0] sym,
                                      input logic [31:0] bits, input logic [5:0] len,
                                      output word_res_t r0, output word_res_t r1);
    int cnt;
    int n;
    logic [31:0] cw;
    cnt = 0;
    r0  = '0;
    r1  = '0;
    case (op)
      OP_LOAD: begin
        if (int'(sym) < P_NUM_SYMBOLS) begin
          code_mem[sym]    = bits;
          len_mem[sym]     = (int'(len) > LEN_CAP) ? 6'(LEN_CAP) : len;
          code_loaded[sym] = 1'b1;
        end
      end
      OP_ENCODE: begin
        if (packer_halted || int'(sym) >= P_NUM_SYMBOLS || !code_loaded[sym]) begin
          packer_halted = 1'b1;
          r0.kind = KIND_ERROR;
          r0.last = 1'b1;
          cnt = 1;
        end else begin
          cw = code_mem[sym];
          n  = int'(len_mem[sym]);
          for (int k = n; k > 0; k--) begin
            acc_bits = {acc_bits[14:0], cw[k-1]};
            acc_fill++;
            if (acc_fill == WORD_BITS) begin
              if (cnt == 0) r0.word = acc_bits;
              else r1.word = acc_bits;
              cnt++;
              acc_bits = '0;
              acc_fill = 0;
            end
          end
          if (cnt == 1) r0.last = 1'b1;
          if (cnt == 2) r1.last = 1'b1;
        end
      end
      OP_FLUSH: begin
        if (packer_halted) begin
          r0.kind = KIND_ERROR;
          r0.last = 1'b1;
          cnt = 1;
        end else if (acc_fill != 0) begin
          r0.word = acc_bits << (WORD_BITS - acc_fill);
          r0.last = 1'b1;
          cnt = 1;
          acc_bits = '0;
          acc_fill = 0;
        end
      end
      default: ;
    endcase
    return cnt;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // offers one request, waits for it to be taken, then records what it should produce
  task automatic send_request(input stim_row_t row);
    word_res_t r0, r1;
    int cnt;
    while (!calm && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= row.op;
    in_ch.symbol    <= row.sym;
    in_ch.code_bits <= row.bits;
    in_ch.code_len  <= row.len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    cnt = pack_request(row.op, row.sym, row.bits, row.len, r0, r1);
    if (row.src == CHECK_FIXED) begin
      // typed-in expectation replaces the predicted one
      cnt = int'(row.n);
      r0  = '{word: row.w0, kind: row.kind, last: (cnt == 1)};
      r1  = '{word: row.w1, kind: row.kind, last: 1'b1};
    end
    if (cnt > 0) pending_words.push_back(r0);
    if (cnt > 1) pending_words.push_back(r1);
    if (cnt > 1) n_pairs++;

    case (row.op)
      OP_LOAD: begin
        n_loads++;
        loaded_syms.push_back(row.sym);
      end
      OP_ENCODE: n_encodes++;
      OP_FLUSH:  n_flushes++;
      default:   n_unused++;
    endcase
  endtask

  // receiver: checks every accepted word, idles at random, honors the long hold
  initial begin
    int hold_left;
    word_res_t want;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (out_ch.kind == KIND_ERROR) n_errors++;
        else n_words++;
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected result word", out_ch.out_word, 16'h0);
        end else begin
          want = pending_words.pop_front();
          if (out_ch.out_word !== want.word)
            report_mismatch("out_word", out_ch.out_word, want.word);
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", 16'(out_ch.kind), 16'(want.kind));
          if (out_ch.last !== want.last)
            report_mismatch("last", 16'(out_ch.last), 16'(want.last));
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycles, pending_words.size());
      $display("prefix_code_bit_packer_top regression: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int r;
    mismatches    = 0;
    cycles        = 0;
    n_loads       = 0;
    n_encodes     = 0;
    n_flushes     = 0;
    n_unused      = 0;
    n_words       = 0;
    n_errors      = 0;
    n_pairs       = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    acc_bits      = '0;
    acc_fill      = 0;
    packer_halted = 1'b0;
    for (int s = 0; s < P_NUM_SYMBOLS; s++) code_loaded[s] = 1'b0;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_LOAD;
    in_ch.symbol    <= '0;
    in_ch.code_bits <= '0;
    in_ch.code_len  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows up to the halt sequence
    for (int i = 0; i < HALT_ROW; i++) send_request(plan[i]);

    // sender pause: let every pending word drain before the random part
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);

    // random traffic: mostly encodes of loaded symbols, with loads, flushes and noise
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 60) hold_req = 1'b1;
      calm = (k >= 200 && k < 330);
      row.src  = CHECK_PREDICTED;
      row.n    = 2'd0;
      row.kind = KIND_DATA;
      row.w0   = '0;
      row.w1   = '0;
      row.bits = $urandom;
      row.len  = 6'($urandom_range(63));
      row.sym  = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 18) begin
        row.op = OP_LOAD;
        while (row.sym == UNKNOWN_SYM) row.sym = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 60)      row.len = 6'($urandom_range(16, 1));
        else if (r < 85) row.len = 6'($urandom_range(32, 17));
        else if (r < 92) row.len = 6'd0;
        else             row.len = 6'($urandom_range(63, 33));
      end else if (r < 85) begin
        row.op  = OP_ENCODE;
        row.sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
      end else if (r < 95) begin
        row.op = OP_FLUSH;
      end else begin
        row.op = OP_UNUSED;
      end
      send_request(row);
    end
    calm = 1'b0;

    // unknown symbol and everything that follows the halt
    for (int i = HALT_ROW; i < NUM_ROWS; i++) send_request(plan[i]);
    in_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests: %0d loads, %0d encodes, %0d flushes, %0d unused op",
             n_loads + n_encodes + n_flushes + n_unused, n_loads, n_encodes,
             n_flushes, n_unused);
    $display("checked %0d data words (%0d two-word encodes) and %0d error results",
             n_words, n_pairs, n_errors);
    if (mismatches == 0) begin
      $display("prefix_code_bit_packer_top regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("prefix_code_bit_packer_top regression: fail");
    end
    $finish;
  end

endmodule
